// File: src/dspv_pkg.sv
// shared types and constants for the dos short path validator
// no dependencies; imported by dspv_step, dos_short_path_validator and the testbench
package dspv_pkg;

  // register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_NAME_LIMIT = 2'd0;
  localparam logic [1:0] REG_EXT_LIMIT  = 2'd1;
  localparam logic [1:0] REG_HIGH_BYTES = 2'd2;

  // reset values of the configuration registers
  localparam logic [3:0] NAME_LIMIT_RST = 4'd8;
  localparam logic [3:0] EXT_LIMIT_RST  = 4'd3;

  // part length counter saturates here
  localparam logic [4:0] PART_SAT = 5'd16;

  // characters with a meaning of their own
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  // configuration as seen by the per-byte logic
  typedef struct packed {
    logic [3:0] name_limit;
    logic [3:0] ext_limit;
    logic       high_bytes_allowed;
  } dspv_cfg_t;

  // per-path scan state
  typedef struct packed {
    logic [1:0] seen_count;
    logic       first_is_letter;
    logic [4:0] part_count;
    logic       dot_seen;
    logic       wild_seen;
    logic       error_flag;
    logic       prev_sep_or_colon;
  } dspv_state_t;

endpackage

// File: src/dspv_step.sv
// per-byte update of the path scan state and the path verdict
// depends on dspv_pkg
module dspv_step import dspv_pkg::*; (
  input  dspv_state_t st,
  input  dspv_cfg_t   cfg,
  input  logic [7:0]  char_in,
  input  logic        last,
  output dspv_state_t st_nxt,
  output logic        valid_res
);

  // characters that may never stand in a name
  function automatic logic is_forbidden(input logic [7:0] c);
    // \ / [ ] { } : | < > + = , ; . " ? *
    return c inside {8'h5C, 8'h2F, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3A, 8'h7C, 8'h3C,
                     8'h3E, 8'h2B, 8'h3D, 8'h2C, 8'h3B, 8'h2E, 8'h22, 8'h3F, 8'h2A};
  endfunction

  // count one name character and check it against the active limit
  function automatic dspv_state_t count_char(input dspv_state_t s_in, input dspv_cfg_t cf);
    dspv_state_t s;
    logic [4:0]  lim;
    s = s_in;
    if (s.part_count < PART_SAT) s.part_count = s.part_count + 5'd1;
    lim = s.dot_seen ? {1'b0, cf.ext_limit} : {1'b0, cf.name_limit};
    if (s.part_count > lim) s.error_flag = 1'b1;
    return s;
  endfunction

  // 8.3 rules for one byte of a part
  function automatic dspv_state_t take_byte(input dspv_state_t s_in, input logic [7:0] c,
                                            input dspv_cfg_t cf);
    dspv_state_t s;
    s = s_in;
    if (c == CH_BSLASH) begin
      if (s.wild_seen) s.error_flag = 1'b1;
      s.part_count = '0;
      s.dot_seen   = 1'b0;
      s.wild_seen  = 1'b0;
    end else if (c == CH_DOT) begin
      if (s.dot_seen) begin
        s.error_flag = 1'b1;
      end else begin
        s.dot_seen   = 1'b1;
        s.part_count = '0;
      end
    end else if (c == CH_STAR || c == CH_QMARK) begin
      s.wild_seen = 1'b1;
      s = count_char(s, cf);
    end else if (c <= CH_SPACE || is_forbidden(c) || (c[7] && !cf.high_bytes_allowed)) begin
      s.error_flag = 1'b1;
    end else begin
      s = count_char(s, cf);
    end
    return s;
  endfunction

  dspv_state_t s;
  logic        is_letter;

  // leading space skip, drive letter detection, then part rules
  always_comb begin
    s = st;
    is_letter = (char_in >= 8'h41 && char_in <= 8'h5A) || (char_in >= 8'h61 && char_in <= 8'h7A);
    if (!(st.seen_count == 2'd0 && char_in == CH_SPACE)) begin
      case (st.seen_count)
        2'd0: begin
          s.first_is_letter = is_letter;
          s = take_byte(s, char_in, cfg);
          s.seen_count = 2'd1;
        end
        2'd1: begin
          if (char_in == CH_COLON && st.first_is_letter) begin
            s.part_count = '0;
            s.dot_seen   = 1'b0;
            s.wild_seen  = 1'b0;
            s.error_flag = 1'b0;
          end else begin
            s = take_byte(s, char_in, cfg);
          end
          s.seen_count = 2'd2;
        end
        default: begin
          s = take_byte(s, char_in, cfg);
        end
      endcase
      s.prev_sep_or_colon = (char_in == CH_BSLASH) || (char_in == CH_COLON);
    end
    valid_res = (s.seen_count != 2'd0) && !s.error_flag && !s.prev_sep_or_colon;
    st_nxt    = last ? '0 : s;
  end

endmodule

// File: src/dos_short_path_validator.sv
// top level of the dos short path validator: config registers, scan state, result register
// depends on dspv_pkg and dspv_step
//
// usage
// - input channel (in_valid/in_ready, in_char_in, in_last) carries one path byte per beat;
//   in_last marks the final byte of a path
// - output channel (out_valid/out_ready, out_valid_res) carries one beat per path,
//   1 when the whole path is a valid 8.3 name
// - one byte is taken every cycle while in_ready is high; the scan state is updated at the accepting edge
// - the verdict of a path is loaded into the output register when its last byte is accepted
// - while the result register holds a beat that the receiver has not taken, in_ready
//   falls; it rises again in the cycle the beat is taken, when a new byte can be accepted
// - reset (rst_n low, synchronous) clears the scan state, empties the result register and
//   loads name_limit 8, ext_limit 3, high_bytes_allowed 0
// - configuration over the apb port: name_limit at 0x0, ext_limit at 0x4,
//   high_bytes_allowed at 0x8; write only while no path is in progress
module dos_short_path_validator import dspv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dspv_cfg_t   cfg_r;
  dspv_state_t st_r;
  dspv_state_t st_nxt;
  logic        res_nxt;
  logic        out_valid_r;
  logic        out_res_r;
  logic        in_fire;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.name_limit         <= NAME_LIMIT_RST;
      cfg_r.ext_limit          <= EXT_LIMIT_RST;
      cfg_r.high_bytes_allowed <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NAME_LIMIT: cfg_r.name_limit         <= pwdata[3:0];
        REG_EXT_LIMIT:  cfg_r.ext_limit          <= pwdata[3:0];
        REG_HIGH_BYTES: cfg_r.high_bytes_allowed <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_NAME_LIMIT: prdata = {28'd0, cfg_r.name_limit};
      REG_EXT_LIMIT:  prdata = {28'd0, cfg_r.ext_limit};
      REG_HIGH_BYTES: prdata = {31'd0, cfg_r.high_bytes_allowed};
      default:        prdata = '0;
    endcase
  end

  // input handshake
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // per-byte logic
  dspv_step u_step (
    .st        (st_r),
    .cfg       (cfg_r),
    .char_in   (in_char_in),
    .last      (in_last),
    .st_nxt    (st_nxt),
    .valid_res (res_nxt)
  );

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last) out_res_r <= res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

  // a last beat always produces a result beat
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> out_valid)
    else $error("no result after last byte");

  // a last beat clears the scan state for the next path
  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> st_r == '0)
    else $error("scan state not cleared after last byte");

  // scan state only moves on an accepted beat
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(st_r))
    else $error("scan state changed without an input beat");

  // counters stay within their saturation points
  a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.part_count <= PART_SAT && st_r.seen_count != 2'd3)
    else $error("scan counter out of range");

  // a stalled result never loses its beat to a new path
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

endmodule

// File: dv/tb_dos_short_path_validator.sv
// testbench for dos_short_path_validator: path bytes in, one validity verdict per path out
// depends on dspv_pkg and the validator rtl; holds its own scan predictor and checks verdicts
module tb_dos_short_path_validator import dspv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_valid_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dos_short_path_validator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_in   (in_char_in),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // limits as the predictor sees them
  logic [3:0] lim_name;
  logic [3:0] lim_ext;
  logic       allow_high;

  // predicted scan state of the current path
  logic [1:0] seen_cnt;
  logic       first_letter;
  logic [4:0] part_len;
  logic       dot_in_part;
  logic       wild_in_part;
  logic       path_bad;
  logic       ends_sep;

  logic        verdict_q[$];
  logic        exp_verdict;
  int unsigned err_cnt;
  int unsigned beats_sent;
  bit          tx_gaps;
  bit          rx_gaps;
  int          hold_left;
  int          stall_left;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_reserved_char(input logic [7:0] c);
    case (c)
      CH_BSLASH, "/", "[", "]", "{", "}", CH_COLON, "|", "<", ">",
      "+", "=", ",", ";", CH_DOT, "\"", CH_QMARK, CH_STAR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_part();
    part_len     = '0;
    dot_in_part  = 1'b0;
    wild_in_part = 1'b0;
  endfunction

  function automatic void clear_path();
    seen_cnt     = '0;
    first_letter = 1'b0;
    path_bad     = 1'b0;
    ends_sep     = 1'b0;
    clear_part();
  endfunction

  // one more name or extension character, checked against the active limit
  function automatic void count_name_char();
    logic [4:0] lim;
    if (part_len < PART_SAT) part_len = part_len + 5'd1;
    lim = dot_in_part ? {1'b0, lim_ext} : {1'b0, lim_name};
    if (part_len > lim) path_bad = 1'b1;
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      // wildcards only allowed in the final part
      if (wild_in_part) path_bad = 1'b1;
      clear_part();
    end else if (c == CH_DOT) begin
      if (dot_in_part) begin
        path_bad = 1'b1;
      end else begin
        dot_in_part = 1'b1;
        part_len    = '0;
      end
    end else if (c == CH_STAR || c == CH_QMARK) begin
      wild_in_part = 1'b1;
      count_name_char();
    end else if (c <= CH_SPACE || is_reserved_char(c) || (c[7] && !allow_high)) begin
      path_bad = 1'b1;
    end else begin
      count_name_char();
    end
  endfunction

  // advance the predicted scan by one byte; returns 1 when a verdict is due
  function automatic bit scan_path_byte(input logic [7:0] c, input logic lst,
                                        output logic verdict);
    verdict = 1'b0;
    // leading spaces are skipped
    if (!(seen_cnt == 2'd0 && c == CH_SPACE)) begin
      if (seen_cnt == 2'd0) begin
        first_letter = is_letter(c);
        scan_byte(c);
        seen_cnt = 2'd1;
      end else if (seen_cnt == 2'd1) begin
        // drive letter resets whatever the letter did
        if (c == CH_COLON && first_letter) begin
          clear_part();
          path_bad = 1'b0;
        end else begin
          scan_byte(c);
        end
        seen_cnt = 2'd2;
      end else begin
        scan_byte(c);
      end
      ends_sep = (c == CH_BSLASH || c == CH_COLON);
    end
    if (!lst) return 1'b0;
    verdict = (seen_cnt != 2'd0) && !path_bad && !ends_sep;
    clear_path();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  // one path byte; returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] c, input logic lst);
    logic v;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    in_last    <= lst;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (scan_path_byte(c, lst, v)) verdict_q.push_back(v);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_path(input logic [7:0] p[$]);
    for (int i = 0; i < p.size(); i++) send_byte(p[i], i == p.size() - 1);
  endtask

  // stop offering bytes and let the last verdict drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
  endtask

  task automatic set_limits(input logic [3:0] n, input logic [3:0] e, input logic h);
    wait_idle();
    write_reg(REG_NAME_LIMIT, {28'd0, n});
    write_reg(REG_EXT_LIMIT, {28'd0, e});
    write_reg(REG_HIGH_BYTES, {31'd0, h});
    psel   <= 1'b0;
    pwrite <= 1'b0;
    lim_name   = n;
    lim_ext    = e;
    allow_high = h;
  endtask

  // ---------------------------------------------------------------- random paths

  function automatic int pick_len(input logic [3:0] lim);
    if ($urandom_range(0, 5) == 0) return int'(lim) + 1;
    return $urandom_range(0, int'(lim));
  endfunction

  function automatic logic [7:0] pick_char(input bit final_part);
    string sym;
    int    r;
    sym = "!#$%&'()-@^_`~";
    r   = $urandom_range(0, 19);
    if (r < 5) return 8'($urandom_range(65, 90));
    if (r < 10) return 8'($urandom_range(97, 122));
    if (r < 13) return 8'($urandom_range(48, 57));
    if (r < 16) return sym[$urandom_range(0, sym.len() - 1)];
    if (r < 18 && (allow_high || $urandom_range(0, 3) == 0))
      return 8'($urandom_range(128, 255));
    if (r == 18 && (final_part || $urandom_range(0, 3) == 0))
      return $urandom_range(0, 1) ? CH_STAR : CH_QMARK;
    return 8'($urandom_range(97, 122));
  endfunction

  // mostly well formed 8.3 paths, with some corruption mixed in
  function automatic void make_path(ref logic [7:0] p[$]);
    int nparts;
    int nlen;
    p.delete();
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) p.push_back(CH_SPACE);
    if ($urandom_range(0, 2) == 0) begin
      p.push_back(8'($urandom_range(65, 90)));
      p.push_back(CH_COLON);
    end
    if ($urandom_range(0, 3) == 0) p.push_back(CH_BSLASH);
    nparts = $urandom_range(1, 3);
    for (int i = 0; i < nparts; i++) begin
      nlen = pick_len(lim_name);
      repeat (nlen) p.push_back(pick_char(i == nparts - 1));
      if ($urandom_range(0, 1) == 0) begin
        p.push_back(CH_DOT);
        nlen = pick_len(lim_ext);
        repeat (nlen) p.push_back(pick_char(i == nparts - 1));
      end
      if (i != nparts - 1) p.push_back(CH_BSLASH);
    end
    // corruption: a random byte somewhere, or a trailing separator
    if (p.size() != 0 && $urandom_range(0, 5) == 0)
      p[$urandom_range(0, p.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 11) == 0) p.push_back($urandom_range(0, 1) ? CH_BSLASH : CH_COLON);
    if (p.size() == 0) p.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_special_cases();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_text(" ");
    send_text("  A:");
    send_text("a\\");
    send_text("C:X.Y");
    send_text("1:");
    send_text("\\\\B");
    send_text(".");
    send_text("a..");
    send_text("*\\a");
    send_text("A?");
    send_byte(8'h00, 1'b1);
    send_text("a b");
    send_byte("a", 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_limit_extremes();
    set_limits(4'd1, 4'd0, 1'b0);
    send_text("a");
    send_text("ab");
    send_text("a.");
    send_text("a.b");
    set_limits(4'd15, 4'd15, 1'b1);
    send_text("ABCDEFGHIJKLMNO.PQRSTUVWXYZ0123");
    send_text("ABCDEFGHIJKLMNOP");
    send_byte(8'hE9, 1'b0);
    send_byte("x", 1'b1);
    // zero name limit rejects any name character
    set_limits(4'd0, 4'd15, 1'b0);
    send_text("a");
    send_text(".b");
  endtask

  task automatic test_random_paths(input int unsigned beat_goal);
    logic [7:0]  p[$];
    int unsigned stop_at;
    stop_at = beats_sent + beat_goal;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        set_limits(NAME_LIMIT_RST, EXT_LIMIT_RST, 1'b0);
      else
        set_limits(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
      for (int n = 0; n < 30 && beats_sent < stop_at; n++) begin
        make_path(p);
        send_path(p);
      end
    end
  endtask

  // receiver holds off while bytes keep coming, so the result register fills
  task automatic test_backpressure();
    logic [7:0] p[$];
    wait_idle();
    tx_gaps   = 1'b0;
    rx_gaps   = 1'b0;
    hold_left = 100;
    repeat (20) begin
      make_path(p);
      send_path(p);
    end
  endtask

  task automatic test_steady_stream(input int unsigned beat_goal);
    logic [7:0]  p[$];
    int unsigned stop_at;
    stop_at = beats_sent + beat_goal;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_limits(NAME_LIMIT_RST, EXT_LIMIT_RST, 1'b1);
    while (beats_sent < stop_at) begin
      make_path(p);
      send_path(p);
    end
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (verdict_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      err_cnt++;
    end
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // ready with random stall bursts, plus a long counted hold when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each verdict beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict beat, valid_res=%0b", out_valid_res);
        err_cnt++;
      end else begin
        exp_verdict = verdict_q.pop_front();
        if (out_valid_res !== exp_verdict) begin
          $error("valid_res mismatch: expected %0b, actual %0b", exp_verdict, out_valid_res);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_char_in = '0;
    in_last    = 1'b0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    err_cnt    = 0;
    beats_sent = 0;
    tx_gaps    = 1'b0;
    rx_gaps    = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    lim_name   = NAME_LIMIT_RST;
    lim_ext    = EXT_LIMIT_RST;
    allow_high = 1'b0;
    clear_path();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_limit_extremes();
    test_random_paths(1000);
    test_backpressure();
    test_steady_stream(300);
    finish_run();
  end

  // run limit
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
src/dspv_pkg.sv
src/dspv_step.sv
src/dos_short_path_validator.sv
dv/tb_dos_short_path_validator.sv
